/* hdl/adcssd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants for the converter seven-segment formatter.
// No dependencies; imported by every other module of the block.
package adcssd_pkg;

  // Mode switch codes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_DEC  = 2'd1;
  localparam logic [1:0] MODE_CH1  = 2'd2;
  localparam logic [1:0] MODE_CH0  = 2'd3;

  // Glyph codes with a meaning of their own
  localparam logic [3:0] GLYPH_ZERO = 4'h0;
  localparam logic [3:0] GLYPH_ONE  = 4'h1;
  localparam logic [3:0] GLYPH_TWO  = 4'h2;
  localparam logic [3:0] GLYPH_E    = 4'hE;

  // Scaling: v = floor(sample * SCALE_NUM / SCALE_DEN), estimate by reciprocal
  localparam logic [23:0] SCALE_NUM   = 24'd10000000;
  localparam logic [25:0] SCALE_DEN   = 26'd40990991;
  localparam logic [21:0] SCALE_RECIP = 22'd4092903;  // floor(2^24 * NUM / DEN)
  localparam int          SCALE_SHIFT = 24;

  // Decimal split by reciprocal multiply, exact for the value ranges used here
  localparam logic [5:0] RECIP_100 = 6'd41;   // / 100 as * 41 >> 12, v < 1000
  localparam int         SHIFT_100 = 12;
  localparam logic [7:0] RECIP_10  = 8'd205;  // / 10 as * 205 >> 11, r < 100
  localparam int         SHIFT_10  = 11;

  // Active-high segment patterns a..g in bits 0..6 for hex 0..F
  localparam logic [6:0] GLYPH [16] = '{
    7'd63, 7'd6, 7'd91, 7'd79, 7'd102, 7'd109, 7'd125, 7'd39,
    7'd127, 7'd111, 7'd119, 7'd124, 7'd57, 7'd94, 7'd121, 7'd113
  };

  // Item sideband travelling down the pipeline
  typedef struct packed {
    logic [1:0]  mode;
    logic        pressed;
    logic [11:0] smp;
  } item_t;

  typedef logic [7:0] seg_t;

  // Active-low segment word, decimal point in bit 7
  function automatic seg_t seg_word(input logic [3:0] digit, input logic dot);
    seg_word = ~{dot, GLYPH[digit]};
  endfunction

endpackage

/* hdl/adcssd_scale.sv */
`timescale 1ns / 1ps
// Two-stage exact scaling of the sample: reciprocal estimate, then one correction.
// Depends on adcssd_pkg.
module adcssd_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  adcssd_pkg::item_t   in_item,
  output logic                valid,
  output adcssd_pkg::item_t   item,
  output logic [9:0]          value
);
  import adcssd_pkg::*;

  logic        s1_valid;
  item_t       s1_item;
  logic [35:0] s1_prod;
  logic [9:0]  s1_est;
  logic [33:0] est_wide;
  logic [9:0]  est_inc;
  logic [35:0] check;

  assign est_wide = 34'(in_item.smp) * 34'(SCALE_RECIP);
  assign est_inc  = s1_est + 10'd1;
  assign check    = 36'(est_inc) * 36'(SCALE_DEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      valid    <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      valid    <= s1_valid;
    end
    if (en) begin
      s1_item <= in_item;
      s1_prod <= 36'(in_item.smp) * 36'(SCALE_NUM);
      s1_est  <= est_wide[SCALE_SHIFT +: 10];
      item    <= s1_item;
      // estimate is never above the quotient and at most one below
      value   <= (check <= s1_prod) ? est_inc : s1_est;
    end
  end

endmodule

/* hdl/adcssd_digits.sv */
`timescale 1ns / 1ps
// Three-stage decimal split and glyph encoding into four segment words.
// Depends on adcssd_pkg.
module adcssd_digits (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  adcssd_pkg::item_t   in_item,
  input  logic [9:0]          in_value,
  output logic                valid,
  output adcssd_pkg::seg_t    words [4]
);
  import adcssd_pkg::*;

  logic        s3_valid, s4_valid;
  item_t       s3_item, s4_item;
  logic [9:0]  s3_value;
  logic [3:0]  s3_hund, s4_hund;
  logic [6:0]  s4_rem;
  logic [15:0] hund_wide;
  logic [9:0]  hund_sub;
  logic [14:0] tens_wide;
  logic [3:0]  tens, ones;
  logic [6:0]  tens_sub;
  logic [3:0]  chan;
  seg_t        d0, d1, d2;

  assign hund_wide = 16'(in_value) * 16'(RECIP_100);
  assign hund_sub  = 10'(s3_hund) * 10'd100;
  assign tens_wide = 15'(s4_rem) * 15'(RECIP_10);
  assign tens      = tens_wide[SHIFT_10 +: 4];
  assign tens_sub  = 7'(tens) * 7'd10;
  assign ones      = 4'(s4_rem - tens_sub);

  always_comb begin
    unique case (s4_item.mode)
      MODE_CH0: chan = GLYPH_ZERO;
      MODE_CH1: chan = GLYPH_ONE;
      MODE_DEC: chan = GLYPH_TWO;
      default:  chan = GLYPH_E;
    endcase
    if (s4_item.mode == MODE_NONE) begin
      d0 = seg_word(GLYPH_E, 1'b0);
      d1 = d0;
      d2 = d0;
    end else if (!s4_item.pressed) begin
      d0 = seg_word(GLYPH_ZERO, 1'b0);
      d1 = d0;
      d2 = d0;
    end else if (s4_item.mode == MODE_DEC) begin
      d0 = seg_word(ones, 1'b0);
      d1 = seg_word(tens, 1'b0);
      d2 = seg_word(s4_hund, 1'b1);
    end else begin
      d0 = seg_word(s4_item.smp[3:0], 1'b0);
      d1 = seg_word(s4_item.smp[7:4], 1'b0);
      d2 = seg_word(s4_item.smp[11:8], 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      valid    <= 1'b0;
    end else if (en) begin
      s3_valid <= in_valid;
      s4_valid <= s3_valid;
      valid    <= s4_valid;
    end
    if (en) begin
      s3_item  <= in_item;
      s3_value <= in_value;
      s3_hund  <= hund_wide[SHIFT_100 +: 4];
      s4_item  <= s3_item;
      s4_hund  <= s3_hund;
      s4_rem   <= 7'(s3_value - hund_sub);
      words[0] <= seg_word(chan, 1'b0);
      words[1] <= d0;
      words[2] <= d1;
      words[3] <= d2;
    end
  end

endmodule

/* hdl/adcssd_serial.sv */
`timescale 1ns / 1ps
// Output serialiser: holds four segment words and sends one per transfer.
// Depends on adcssd_pkg.
module adcssd_serial (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  adcssd_pkg::seg_t    in_words [4],
  output logic                can_load,
  output logic                word_valid,
  input  logic                word_ready,
  output logic [1:0]          digit_index,
  output logic [7:0]          segment_bits,
  output logic                last_digit
);
  import adcssd_pkg::*;

  logic       busy;
  logic [1:0] cnt;
  seg_t       words [4];
  logic       take, done;

  assign take     = busy && word_ready;
  assign done     = take && (cnt == 2'd3);
  assign can_load = !busy || done;

  assign word_valid   = busy;
  assign segment_bits = words[cnt];
  assign digit_index  = cnt + 2'd3;  // order 3, 0, 1, 2
  assign last_digit   = (cnt == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (in_valid && can_load) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
    end else if (done) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (take) begin
      cnt <= cnt + 2'd1;
    end
    if (in_valid && can_load) begin
      words <= in_words;
    end
  end

endmodule

/* hdl/adc_seven_segment_display_formatter_unit.sv */
`timescale 1ns / 1ps
// Converter seven-segment formatter: one item in, four segment words out.
// Path: stages 1-2 scale, stages 3-5 split and encode, then the serialiser sends an
// item's four words one per transfer; the single output word port sets the item rate;
//   the five arithmetic stages take an item every cycle while the serialiser has room.
// Reset: synchronous, active high; clears all stage valid bits and the serialiser.
module adc_seven_segment_display_formatter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  mode_switches,
  input  logic        button_pressed,
  input  logic [11:0] sample,
  output logic        word_valid,
  input  logic        word_ready,
  output logic [1:0]  digit_index,
  output logic [7:0]  segment_bits,
  output logic        last_digit
);
  import adcssd_pkg::*;

  item_t      in_item;
  logic       en;
  logic       sc_valid;
  item_t      sc_item;
  logic [9:0] sc_value;
  logic       dg_valid;
  seg_t       dg_words [4];
  logic       ser_can_load;

  assign in_item = '{mode: mode_switches, pressed: button_pressed, smp: sample};

  // Advance the whole pipeline together whenever the last stage is empty or
  // is handing its words to the serialiser; otherwise hold every stage.
  assign en         = !dg_valid || ser_can_load;
  assign item_ready = en;

  // Stages 1-2: exact scaling for the decimal channel
  adcssd_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (item_valid),
    .in_item  (in_item),
    .valid    (sc_valid),
    .item     (sc_item),
    .value    (sc_value)
  );

  // Stages 3-5: decimal split, channel selection and glyph encoding
  adcssd_digits u_digits (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sc_valid),
    .in_item  (sc_item),
    .in_value (sc_value),
    .valid    (dg_valid),
    .words    (dg_words)
  );

  // Output: one word per transfer, digit 3 first, last flag on digit 2
  adcssd_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (dg_valid),
    .in_words     (dg_words),
    .can_load     (ser_can_load),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .digit_index  (digit_index),
    .segment_bits (segment_bits),
    .last_digit   (last_digit)
  );

  // The last flag marks digit 2 and only digit 2
  a_last_on_digit2: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> (last_digit == (digit_index == 2'd2)))
    else $error("last_digit does not match digit 2");

  // The pipeline only stalls when the serialiser holds a word
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> word_valid)
    else $error("input stalled with no word pending");

  // The channel word is followed at once by digit 0 of the same item
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (word_valid && word_ready && digit_index == 2'd3) |=>
      (word_valid && digit_index == 2'd0))
    else $error("word run broken after channel digit");

endmodule
